@@ rtl/utf8v_pkg.sv @@
// Shared types and constants for the UTF-8 text validator.
package utf8v_pkg;

    // Verdict codes carried on the result item
    localparam logic [1:0] VERDICT_MORE   = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
    localparam logic [1:0] VERDICT_REJECT = 2'd2;

    // Byte-order mark bytes
    localparam logic [7:0] MARK_B0 = 8'hEF;
    localparam logic [7:0] MARK_B1 = 8'hBB;
    localparam logic [7:0] MARK_B2 = 8'hBF;

    // Lead byte ranges and special byte values
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_SPC  = 8'h20;
    localparam logic [7:0] BYTE_DEL  = 8'h7F;

    // Code point limits
    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_SURR_LO = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    // Mark detection finishes after this many bytes
    localparam logic [1:0] MARK_DONE = 2'd3;

    // Per-string decoder context
    typedef struct packed {
        logic [1:0]  pend;        // continuation bytes still expected
        logic [2:0]  seq_len;     // length of the open sequence
        logic [20:0] acc;         // code point being assembled
        logic [1:0]  mark_stage;  // bytes checked against the mark
        logic        mark_match;  // mark still matching
        logic        err;         // error seen
        logic        kept;        // a kept character seen
        logic        visible;     // a character above space seen
        logic        broken;      // non-continuation byte inside sequence
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        pend:       2'd0,
        seq_len:    3'd0,
        acc:        21'd0,
        mark_stage: 2'd0,
        mark_match: 1'b1,
        err:        1'b0,
        kept:       1'b0,
        visible:    1'b0,
        broken:     1'b0
    };

    // One result item
    typedef struct packed {
        logic        ellipsis;
        logic [1:0]  trim;
        logic        bom;
        logic [1:0]  verdict;
    } result_t;

endpackage

@@ rtl/utf8v_step.sv @@
// Combinational decode of one byte against the current string context.
module utf8v_step (
    input  utf8v_pkg::ctx_t    ctx,
    input  logic [7:0]         text_byte,
    input  logic               cut_short,
    input  logic               final_byte,
    output utf8v_pkg::ctx_t    ctx_next,
    output utf8v_pkg::result_t res
);

    always_comb begin
        utf8v_pkg::ctx_t s;
        logic        bom_now;
        logic [7:0]  want;
        logic [20:0] cp;
        logic        bad;
        logic        accepted;
        logic [1:0]  trim;

        s        = ctx;
        bom_now  = 1'b0;
        want     = utf8v_pkg::MARK_B2;
        cp       = {ctx.acc[14:0], text_byte[5:0]};
        bad      = 1'b0;
        accepted = 1'b0;
        trim     = 2'd0;

        // Byte-order mark tracking over the first three bytes
        if (ctx.mark_stage != utf8v_pkg::MARK_DONE) begin
            unique case (ctx.mark_stage)
                2'd0:    want = utf8v_pkg::MARK_B0;
                2'd1:    want = utf8v_pkg::MARK_B1;
                default: want = utf8v_pkg::MARK_B2;
            endcase
            if (text_byte != want) begin
                s.mark_match = 1'b0;
            end
            s.mark_stage = ctx.mark_stage + 2'd1;
            bom_now = (s.mark_stage == utf8v_pkg::MARK_DONE) && s.mark_match;
        end

        // Decode, skipped once an error is recorded
        if (!ctx.err) begin
            priority if (ctx.pend != 2'd0) begin
                if (text_byte[7:6] != 2'b10) begin
                    s.broken = 1'b1;
                end
                s.acc  = cp;
                s.pend = ctx.pend - 2'd1;
                if (ctx.pend == 2'd1) begin
                    // Sequence complete: judge the code point
                    if (s.broken ||
                        (ctx.seq_len == 3'd3 && cp < utf8v_pkg::CP_MIN3) ||
                        (ctx.seq_len == 3'd4 && cp < utf8v_pkg::CP_MIN4) ||
                        (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI) ||
                        cp > utf8v_pkg::CP_MAX) begin
                        s.err = 1'b1;
                    end else if (!bom_now) begin
                        s.kept    = 1'b1;
                        s.visible = 1'b1;
                    end
                    s.seq_len = 3'd0;
                    s.acc     = 21'd0;
                    s.broken  = 1'b0;
                end
            end else if (!text_byte[7]) begin
                // ASCII: controls other than tab, and DEL, are errors
                if ((text_byte < utf8v_pkg::BYTE_SPC && text_byte != utf8v_pkg::BYTE_TAB) ||
                    text_byte == utf8v_pkg::BYTE_DEL) begin
                    s.err = 1'b1;
                end else begin
                    s.kept = 1'b1;
                    if (text_byte > utf8v_pkg::BYTE_SPC) begin
                        s.visible = 1'b1;
                    end
                end
            end else if (text_byte >= utf8v_pkg::LEAD2_LO && text_byte <= utf8v_pkg::LEAD2_HI) begin
                s.seq_len = 3'd2;
                s.acc     = {16'd0, text_byte[4:0]};
                s.pend    = 2'd1;
                s.broken  = 1'b0;
            end else if (text_byte >= utf8v_pkg::LEAD3_LO && text_byte <= utf8v_pkg::LEAD3_HI) begin
                s.seq_len = 3'd3;
                s.acc     = {17'd0, text_byte[3:0]};
                s.pend    = 2'd2;
                s.broken  = 1'b0;
            end else if (text_byte >= utf8v_pkg::LEAD4_LO && text_byte <= utf8v_pkg::LEAD4_HI) begin
                s.seq_len = 3'd4;
                s.acc     = {18'd0, text_byte[2:0]};
                s.pend    = 2'd3;
                s.broken  = 1'b0;
            end else begin
                s.err = 1'b1;
            end
        end

        // Verdict on the last byte
        res = '{ellipsis: 1'b0, trim: 2'd0, bom: 1'b0, verdict: utf8v_pkg::VERDICT_MORE};
        if (final_byte) begin
            bad = s.err;
            if (!bad && s.pend != 2'd0) begin
                if (cut_short) begin
                    trim = 2'(s.seq_len - {1'b0, s.pend});
                end else begin
                    bad = 1'b1;
                end
            end
            accepted    = !bad && s.kept && (s.visible || cut_short);
            res.verdict = accepted ? utf8v_pkg::VERDICT_ACCEPT : utf8v_pkg::VERDICT_REJECT;
            res.bom     = (s.mark_stage == utf8v_pkg::MARK_DONE) && s.mark_match;
            if (accepted) begin
                res.trim     = trim;
                res.ellipsis = cut_short;
            end
        end

        ctx_next = final_byte ? utf8v_pkg::CTX_RESET : s;
    end

endmodule

@@ rtl/utf8v_ctx.sv @@
// String context register, advanced by one decoded byte per enabled cycle.
module utf8v_ctx (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [7:0]         text_byte,
    input  logic               cut_short,
    input  logic               final_byte,
    output utf8v_pkg::result_t res
);

    utf8v_pkg::ctx_t ctx_reg;
    utf8v_pkg::ctx_t ctx_next;

    utf8v_step u_step (
        .ctx        (ctx_reg),
        .text_byte  (text_byte),
        .cut_short  (cut_short),
        .final_byte (final_byte),
        .ctx_next   (ctx_next),
        .res        (res)
    );

    // Context update, back to start of string after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg <= utf8v_pkg::CTX_RESET;
        end else if (step_en) begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

@@ rtl/utf8_text_validator.sv @@
// Strict UTF-8 string validator, one byte per item, top level.
// Each item passes the input register and then the result register before output.
// Throughput: one item per cycle while the result register is free or being drained;
// the byte decode is a single combinational step between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and returns the
// string context to start of string.
module utf8_text_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic [0:0] s_tuser,   // [0] cut_short
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] verdict, [2] bom_dropped, [4:3] trim_count,
                                  // [5] add_ellipsis, [7:6] zero
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_cut_reg;
    logic               in_last_reg;
    logic               out_valid_reg;
    utf8v_pkg::result_t out_res_reg;
    utf8v_pkg::result_t res;
    logic               advance;

    // Item moves into the result register when it is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_cut_reg  <= s_tuser[0];
            in_last_reg <= s_tlast;
        end
    end

    utf8v_ctx u_ctx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .text_byte  (in_byte_reg),
        .cut_short  (in_cut_reg),
        .final_byte (in_last_reg),
        .res        (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

endmodule

@@ dv/tb_utf8_text_validator.sv @@
// Stream testbench for the UTF-8 text validator: random strings, predicted verdicts, checker.
module tb_utf8_text_validator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;
    localparam int BYTE_TARGET = 1150;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       cut_short;
        logic       final_byte;
    } text_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;   // [7:0] text_byte
    logic [0:0] s_tuser = '0;   // [0] cut_short
    logic       s_tlast = 1'b0; // final_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;        // [1:0] verdict, [2] bom_dropped, [4:3] trim_count,
                                // [5] add_ellipsis, [7:6] zero

    text_item_t          text_q[$];     // bytes waiting to be offered
    logic [7:0]          str_bytes[$];  // string under construction
    utf8v_pkg::result_t  verdict_q[$];  // predicted results, oldest first
    utf8v_pkg::ctx_t     text_ctx = utf8v_pkg::CTX_RESET;
    int                  errors = 0;
    int                  cyc = 0;
    int                  stall_cycles = 0;

    utf8_text_validator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Random idle decision; a window in the middle of the run never idles
    function automatic logic coin_idle();
        if (cyc >= 400 && cyc < 650)
            return 1'b0;
        return $urandom_range(0, 99) < 7;
    endfunction

    // Decode one byte against the string context and give the item's result
    function automatic utf8v_pkg::result_t predict_verdict(logic [7:0] b, logic cut, logic last);
        utf8v_pkg::result_t res;
        logic [7:0] want;
        logic       bom_now;
        logic       bad;
        logic       ok;
        logic [1:0] trim;
        res = '0;
        res.verdict = utf8v_pkg::VERDICT_MORE;
        bom_now = 1'b0;

        // byte-order mark tracking over the first three bytes
        if (text_ctx.mark_stage < utf8v_pkg::MARK_DONE) begin
            want = (text_ctx.mark_stage == 2'd0) ? utf8v_pkg::MARK_B0 :
                   (text_ctx.mark_stage == 2'd1) ? utf8v_pkg::MARK_B1 : utf8v_pkg::MARK_B2;
            if (b != want)
                text_ctx.mark_match = 1'b0;
            text_ctx.mark_stage = text_ctx.mark_stage + 2'd1;
            if (text_ctx.mark_stage == utf8v_pkg::MARK_DONE && text_ctx.mark_match)
                bom_now = 1'b1;
        end

        // decode, frozen once an error has been seen
        if (!text_ctx.err) begin
            if (text_ctx.pend != 2'd0) begin
                if (b[7:6] != 2'b10)
                    text_ctx.broken = 1'b1;
                text_ctx.acc = {text_ctx.acc[14:0], b[5:0]};
                text_ctx.pend = text_ctx.pend - 2'd1;
                if (text_ctx.pend == 2'd0) begin
                    if (text_ctx.broken ||
                        (text_ctx.seq_len == 3'd3 && text_ctx.acc < utf8v_pkg::CP_MIN3) ||
                        (text_ctx.seq_len == 3'd4 && text_ctx.acc < utf8v_pkg::CP_MIN4) ||
                        (text_ctx.acc >= utf8v_pkg::CP_SURR_LO &&
                         text_ctx.acc <= utf8v_pkg::CP_SURR_HI) ||
                        text_ctx.acc > utf8v_pkg::CP_MAX) begin
                        text_ctx.err = 1'b1;
                    end else if (!bom_now) begin
                        text_ctx.kept = 1'b1;
                        text_ctx.visible = 1'b1;
                    end
                    text_ctx.seq_len = 3'd0;
                    text_ctx.acc = '0;
                    text_ctx.broken = 1'b0;
                end
            end else if (b[7] == 1'b0) begin
                if ((b < utf8v_pkg::BYTE_SPC && b != utf8v_pkg::BYTE_TAB) ||
                    b == utf8v_pkg::BYTE_DEL) begin
                    text_ctx.err = 1'b1;
                end else begin
                    text_ctx.kept = 1'b1;
                    if (b > utf8v_pkg::BYTE_SPC)
                        text_ctx.visible = 1'b1;
                end
            end else if (b >= utf8v_pkg::LEAD2_LO && b <= utf8v_pkg::LEAD2_HI) begin
                text_ctx.seq_len = 3'd2;
                text_ctx.acc = {16'd0, b[4:0]};
                text_ctx.pend = 2'd1;
                text_ctx.broken = 1'b0;
            end else if (b >= utf8v_pkg::LEAD3_LO && b <= utf8v_pkg::LEAD3_HI) begin
                text_ctx.seq_len = 3'd3;
                text_ctx.acc = {17'd0, b[3:0]};
                text_ctx.pend = 2'd2;
                text_ctx.broken = 1'b0;
            end else if (b >= utf8v_pkg::LEAD4_LO && b <= utf8v_pkg::LEAD4_HI) begin
                text_ctx.seq_len = 3'd4;
                text_ctx.acc = {18'd0, b[2:0]};
                text_ctx.pend = 2'd3;
                text_ctx.broken = 1'b0;
            end else begin
                text_ctx.err = 1'b1;
            end
        end

        // verdict on the last byte, then back to start of string
        if (last) begin
            bad = text_ctx.err;
            trim = 2'd0;
            if (!bad && text_ctx.pend != 2'd0) begin
                if (cut)
                    trim = 2'(text_ctx.seq_len - {1'b0, text_ctx.pend});
                else
                    bad = 1'b1;
            end
            ok = !bad && text_ctx.kept && (text_ctx.visible || cut);
            res.verdict = ok ? utf8v_pkg::VERDICT_ACCEPT : utf8v_pkg::VERDICT_REJECT;
            res.bom = (text_ctx.mark_stage == utf8v_pkg::MARK_DONE) && text_ctx.mark_match;
            if (ok) begin
                res.trim = trim;
                res.ellipsis = cut;
            end
            text_ctx = utf8v_pkg::CTX_RESET;
        end
        return res;
    endfunction

    // Move the built string into the send queue, tlast on its final byte
    task automatic push_string(input logic cut_final, input logic cut_rest);
        text_item_t item;
        foreach (str_bytes[i]) begin
            item.text_byte = str_bytes[i];
            item.final_byte = (i == str_bytes.size() - 1);
            item.cut_short = item.final_byte ? cut_final : cut_rest;
            text_q = {text_q, item};
        end
        str_bytes.delete();
    endtask

    // Append one byte to the string under construction
    task automatic add_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endtask

    // Encode a code point in n bytes, without checking that the form is legal
    task automatic append_code(input logic [20:0] cp, input int n);
        case (n)
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            4: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte(cp[7:0]);
            end
        endcase
    endtask

    // Stimulus, reset, and end of run
    initial begin
        int          nchar;
        int          defect_at;
        int          drop;
        int          k;
        int          r;
        logic        has_defect;
        logic        cut;
        logic        edge_pick;
        logic [20:0] cp;
        logic [7:0]  b;

        // directed strings
        str_bytes = '{8'h41};                      push_string(1'b0, 1'b0);
        str_bytes = '{8'hEF, 8'hBB, 8'hBF};        push_string(1'b0, 1'b0); // mark only
        str_bytes = '{8'h09, 8'h20};               push_string(1'b0, 1'b0); // nothing visible
        str_bytes = '{8'h20};                      push_string(1'b1, 1'b1); // saved by ellipsis
        str_bytes = '{8'h00, 8'h7F, 8'h41};        push_string(1'b0, 1'b0); // bytes after error
        str_bytes = '{8'hC1, 8'hFF};               push_string(1'b0, 1'b0); // bad lead bytes
        str_bytes = '{8'hE0, 8'h80, 8'h80};        push_string(1'b0, 1'b0); // overlong
        str_bytes = '{8'hED, 8'hA0, 8'h80};        push_string(1'b0, 1'b0); // surrogate
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; push_string(1'b0, 1'b0); // above 10FFFF
        str_bytes = '{8'h41, 8'hF0, 8'h9F, 8'h98}; push_string(1'b1, 1'b0); // trimmed tail

        // random strings: mostly well formed, some with one defect
        while (text_q.size() < BYTE_TARGET) begin
            has_defect = ($urandom_range(0, 99) < 20);
            nchar = $urandom_range(1, 8);
            defect_at = $urandom_range(0, nchar - 1);
            if ($urandom_range(0, 99) < 15) begin
                add_byte(utf8v_pkg::MARK_B0);
                add_byte(utf8v_pkg::MARK_B1);
                add_byte(($urandom_range(0, 3) == 0) ?
                         8'($urandom_range(0, 255)) : utf8v_pkg::MARK_B2);
            end
            for (int i = 0; i < nchar; i++) begin
                if (has_defect && i == defect_at) begin
                    case ($urandom_range(0, 7))
                        0: begin
                            b = 8'($urandom_range(0, 31));
                            add_byte((b == utf8v_pkg::BYTE_TAB) ? utf8v_pkg::BYTE_DEL : b);
                        end
                        1: add_byte(utf8v_pkg::BYTE_DEL);
                        2: begin
                            // continuation byte as lead, C0/C1, F5..FF
                            r = $urandom_range(8'h80, 8'hCC);
                            if (r > 8'hC1)
                                r = r + (8'hF5 - 8'hC2);
                            add_byte(8'(r));
                        end
                        3: begin
                            k = $urandom_range(2, 4);
                            cp = (k == 2) ? 21'($urandom_range(0, 21'h7F)) :
                                 (k == 3) ? 21'($urandom_range(0, 21'h7FF)) :
                                            21'($urandom_range(0, 21'hFFFF));
                            append_code(cp, k);
                        end
                        4: append_code(21'($urandom_range(utf8v_pkg::CP_SURR_LO,
                                                          utf8v_pkg::CP_SURR_HI)), 3);
                        5: append_code(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
                        6: begin
                            // valid sequence with one continuation byte spoiled
                            k = $urandom_range(2, 4);
                            cp = (k == 2) ? 21'($urandom_range(21'h80, 21'h7FF)) :
                                 (k == 3) ? 21'($urandom_range(21'h800, 21'hD7FF)) :
                                            21'($urandom_range(utf8v_pkg::CP_MIN4,
                                                               utf8v_pkg::CP_MAX));
                            append_code(cp, k);
                            b = 8'($urandom_range(0, 255));
                            if (b[7:6] == 2'b10)
                                b[6] = 1'b1;
                            str_bytes[str_bytes.size() - $urandom_range(1, k - 1)] = b;
                        end
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                end else begin
                    r = $urandom_range(0, 99);
                    edge_pick = ($urandom_range(0, 3) == 0);
                    if (r < 50) begin
                        add_byte(8'($urandom_range(8'h21, 8'h7E)));
                    end else if (r < 60) begin
                        add_byte($urandom_range(0, 1) ? utf8v_pkg::BYTE_TAB :
                                                        utf8v_pkg::BYTE_SPC);
                    end else if (r < 72) begin
                        if (edge_pick)
                            cp = $urandom_range(0, 1) ? 21'h80 : 21'h7FF;
                        else
                            cp = 21'($urandom_range(21'h80, 21'h7FF));
                        append_code(cp, 2);
                    end else if (r < 88) begin
                        if (edge_pick) begin
                            case ($urandom_range(0, 3))
                                0: cp = utf8v_pkg::CP_MIN3;
                                1: cp = utf8v_pkg::CP_SURR_LO - 21'd1;
                                2: cp = utf8v_pkg::CP_SURR_HI + 21'd1;
                                default: cp = 21'hFFFF;
                            endcase
                        end else begin
                            cp = 21'($urandom_range(21'h800, 21'hF7FF));
                            if (cp >= utf8v_pkg::CP_SURR_LO)
                                cp = cp + 21'h800;
                        end
                        append_code(cp, 3);
                    end else begin
                        if (edge_pick)
                            cp = $urandom_range(0, 1) ? utf8v_pkg::CP_MIN4 : utf8v_pkg::CP_MAX;
                        else
                            cp = 21'($urandom_range(utf8v_pkg::CP_MIN4, utf8v_pkg::CP_MAX));
                        append_code(cp, 4);
                    end
                end
            end
            cut = ($urandom_range(0, 99) < 30);
            // truncated strings often lose part of their last sequence
            if (cut && $urandom_range(0, 1) == 1) begin
                drop = $urandom_range(1, 3);
                while (drop > 0 && str_bytes.size() > 1) begin
                    void'(str_bytes.pop_back());
                    drop--;
                end
            end
            push_string(cut, ($urandom_range(0, 99) < 5) ? ~cut : cut);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // all bytes taken, then all results back, then drain
        do @(negedge aclk); while (text_q.size() != 0 || s_tvalid);
        do @(negedge aclk); while (verdict_q.size() != 0);
        repeat (10) @(posedge aclk);
        if (verdict_q.size() != 0) begin
            $error("%0d results never arrived", verdict_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Byte driver: records the prediction when an item is taken, then offers the next
    always @(posedge aclk) begin : drive_bytes
        text_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                verdict_q = {verdict_q, predict_verdict(s_tdata, s_tuser[0], s_tlast)};
            if (!s_tvalid || s_tready) begin
                if (text_q.size() != 0 && !coin_idle()) begin
                    item = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.text_byte;
                    s_tuser <= item.cut_short;
                    s_tlast <= item.final_byte;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls plus long hold-offs to back up the block
    always @(posedge aclk) begin : drive_ready
        int rx_cycles;
        int hold_left;
        if (!aresetn) begin
            rx_cycles = 0;
            hold_left = 0;
            m_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles == 150 || rx_cycles == 900)
                hold_left = 150;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !coin_idle();
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result checker against the oldest prediction
    always @(posedge aclk) begin : check_verdicts
        utf8v_pkg::result_t got;
        utf8v_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = utf8v_pkg::result_t'(m_tdata[5:0]);
            if (verdict_q.size() == 0) begin
                $error("result item 0x%02h with nothing expected", m_tdata);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                check_field("verdict", int'(want.verdict), int'(got.verdict));
                check_field("bom_dropped", int'(want.bom), int'(got.bom));
                check_field("trim_count", int'(want.trim), int'(got.trim));
                check_field("add_ellipsis", int'(want.ellipsis), int'(got.ellipsis));
                check_field("pad", 0, int'(m_tdata[7:6]));
            end
        end
    end

    // Cycle count and watchdog on cycles with no item moving
    always @(posedge aclk) begin : watchdog
        cyc <= cyc + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
